// ----- rtl/assert_macros.svh -----
// Assertion helpers for the placer checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define QMP_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("qmp assertion failed");

// Next-cycle implication, disabled in reset.
`define QMP_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("qmp assertion failed");

`endif

// ----- rtl/qmp_pkg.sv -----
package qmp_pkg;

	// Input item
	typedef struct packed {
		logic [1:0] op;
		logic       data_bit;
		logic [7:0] read_row;
		logic [7:0] read_col;
	} qmp_req_t;

	// Result item
	typedef struct packed {
		logic [1:0] module_code;
		logic [7:0] placed_row;
		logic [7:0] placed_col;
		logic       placed;
		logic       full_res;
	} qmp_rsp_t;

	// Operation codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_PLACE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Module codes
	localparam logic [1:0] CODE_BLACK = 2'd0;
	localparam logic [1:0] CODE_WHITE = 2'd1;
	localparam logic [1:0] CODE_UNSET = 2'd2;
	localparam logic [1:0] CODE_RESV  = 2'd3;

	// Register addresses
	localparam logic [2:0] REG_VERSION = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRD,
		ST_WCHK,
		ST_RWAIT,
		ST_OUT
	} qmp_state_t;

	// Alignment centers per version: element 0 is the count, then the positions.
	typedef logic [0:7][7:0] align_row_t;

	function automatic align_row_t align_row(input logic [5:0] ver);
		case (ver)
			6'd2:  return '{8'd2, 8'd6, 8'd18, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd3:  return '{8'd2, 8'd6, 8'd22, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd4:  return '{8'd2, 8'd6, 8'd26, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd5:  return '{8'd2, 8'd6, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd6:  return '{8'd2, 8'd6, 8'd34, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd7:  return '{8'd3, 8'd6, 8'd22, 8'd38, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd8:  return '{8'd3, 8'd6, 8'd24, 8'd42, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd9:  return '{8'd3, 8'd6, 8'd26, 8'd46, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd10: return '{8'd3, 8'd6, 8'd28, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd11: return '{8'd3, 8'd6, 8'd30, 8'd54, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd12: return '{8'd3, 8'd6, 8'd32, 8'd58, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd13: return '{8'd3, 8'd6, 8'd34, 8'd62, 8'd0, 8'd0, 8'd0, 8'd0};
			6'd14: return '{8'd4, 8'd6, 8'd26, 8'd46, 8'd66, 8'd0, 8'd0, 8'd0};
			6'd15: return '{8'd4, 8'd6, 8'd26, 8'd48, 8'd70, 8'd0, 8'd0, 8'd0};
			6'd16: return '{8'd4, 8'd6, 8'd26, 8'd50, 8'd74, 8'd0, 8'd0, 8'd0};
			6'd17: return '{8'd4, 8'd6, 8'd30, 8'd54, 8'd78, 8'd0, 8'd0, 8'd0};
			6'd18: return '{8'd4, 8'd6, 8'd30, 8'd56, 8'd82, 8'd0, 8'd0, 8'd0};
			6'd19: return '{8'd4, 8'd6, 8'd30, 8'd58, 8'd86, 8'd0, 8'd0, 8'd0};
			6'd20: return '{8'd4, 8'd6, 8'd34, 8'd62, 8'd90, 8'd0, 8'd0, 8'd0};
			6'd21: return '{8'd5, 8'd6, 8'd28, 8'd50, 8'd72, 8'd94, 8'd0, 8'd0};
			6'd22: return '{8'd5, 8'd6, 8'd26, 8'd50, 8'd74, 8'd98, 8'd0, 8'd0};
			6'd23: return '{8'd5, 8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd0, 8'd0};
			6'd24: return '{8'd5, 8'd6, 8'd28, 8'd54, 8'd80, 8'd106, 8'd0, 8'd0};
			6'd25: return '{8'd5, 8'd6, 8'd32, 8'd58, 8'd84, 8'd110, 8'd0, 8'd0};
			6'd26: return '{8'd5, 8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd0, 8'd0};
			6'd27: return '{8'd5, 8'd6, 8'd34, 8'd62, 8'd90, 8'd118, 8'd0, 8'd0};
			6'd28: return '{8'd6, 8'd6, 8'd26, 8'd50, 8'd74, 8'd98, 8'd122, 8'd0};
			6'd29: return '{8'd6, 8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd126, 8'd0};
			6'd30: return '{8'd6, 8'd6, 8'd26, 8'd52, 8'd78, 8'd104, 8'd130, 8'd0};
			6'd31: return '{8'd6, 8'd6, 8'd30, 8'd56, 8'd82, 8'd108, 8'd134, 8'd0};
			6'd32: return '{8'd6, 8'd6, 8'd34, 8'd60, 8'd86, 8'd112, 8'd138, 8'd0};
			6'd33: return '{8'd6, 8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142, 8'd0};
			6'd34: return '{8'd6, 8'd6, 8'd34, 8'd62, 8'd90, 8'd118, 8'd146, 8'd0};
			6'd35: return '{8'd7, 8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd126, 8'd150};
			6'd36: return '{8'd7, 8'd6, 8'd24, 8'd50, 8'd76, 8'd102, 8'd128, 8'd154};
			6'd37: return '{8'd7, 8'd6, 8'd28, 8'd54, 8'd80, 8'd106, 8'd132, 8'd158};
			6'd38: return '{8'd7, 8'd6, 8'd32, 8'd58, 8'd84, 8'd110, 8'd136, 8'd162};
			6'd39: return '{8'd7, 8'd6, 8'd26, 8'd54, 8'd82, 8'd110, 8'd138, 8'd166};
			6'd40: return '{8'd7, 8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142, 8'd170};
			default: return '0;
		endcase
	endfunction

endpackage

// ----- rtl/qr_matrix_module_placer.sv -----
// Start: accept, then write the symbol area module by module, then output.
// Data bit: each module visited on the walk takes a store read, then a check/write;
//   the bit is written to the first free module, or dropped if the walk finds none.
// Read: store read, then output; outside the symbol, output only. One item at a time;
//   the next item is taken while a result waits.
// Reset clears control state and sets version 1; the module store is not cleared
//   by reset, only by a start item.
module qr_matrix_module_placer
	import qmp_pkg::*;
#(
	parameter int MAX_VERSION = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  qmp_req_t    req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output qmp_rsp_t    rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int StoreSide = 21 + 4 * (MAX_VERSION - 1);
	localparam int Depth     = StoreSide * StoreSide;
	localparam int AW        = $clog2(Depth);
	localparam logic [AW-1:0] SIDE_A = AW'(StoreSide);
	localparam logic [5:0]    VMAX   = 6'(MAX_VERSION);

	qmp_state_t state_q, state_d;

	logic [5:0] ver_q, act_ver_q, ver_c;
	logic [7:0] side_q, side_c;
	logic [7:0] walk_col_q, walk_row_q;
	logic       walk_up_q, walk_left_q, walk_done_q;
	logic [7:0] clr_r_q, clr_c_q;
	logic       bit_q;
	qmp_rsp_t   res_q, rsp_q;
	logic       rsp_valid_q;

	logic [1:0]    store_q [Depth];
	logic [1:0]    rd_q;
	logic [AW-1:0] rd_addr, wr_addr, walk_addr;
	logic [1:0]    wr_data, fix_code;
	logic          wr_en;

	logic       acc, cfg_wr, rsp_load, in_range, clr_last;
	logic [7:0] cur_col;
	logic [7:0] adv_col, adv_row;
	logic       adv_up, adv_left, adv_done;

	// configuration port
	assign pready = 1'b1;
	assign prdata = {26'd0, ver_q};
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_VERSION);

	assign req_ready = (state_q == ST_IDLE);
	assign acc       = req_valid && req_ready;
	assign rsp_load  = (state_q == ST_OUT) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// version clamp and side at start
	assign ver_c  = (ver_q == 6'd0) ? 6'd1 : ((ver_q > VMAX) ? VMAX : ver_q);
	assign side_c = 8'({2'b00, ver_c} << 2) + 8'd17;

	assign in_range = (req.read_row < side_q) && (req.read_col < side_q);
	assign clr_last = (clr_r_q == side_q - 8'd1) && (clr_c_q == side_q - 8'd1);

	assign cur_col   = walk_left_q ? walk_col_q - 8'd1 : walk_col_q;
	assign walk_addr = AW'(walk_row_q) * SIDE_A + AW'(cur_col);

	qmp_fixed_marks u_marks (
		.row  (clr_r_q),
		.col  (clr_c_q),
		.side (side_q),
		.ver  (act_ver_q),
		.code (fix_code)
	);

	// next step of the zigzag walk
	always_comb begin
		adv_col  = walk_col_q;
		adv_row  = walk_row_q;
		adv_up   = walk_up_q;
		adv_left = 1'b0;
		adv_done = walk_done_q;
		if (!walk_left_q) begin
			adv_left = 1'b1;
		end else if ((walk_up_q && walk_row_q == 8'd0) ||
		             (!walk_up_q && walk_row_q + 8'd1 >= side_q)) begin
			adv_up = !walk_up_q;
			if (walk_col_q < 8'd2) begin
				adv_done = 1'b1;
				adv_col  = '0;
			end else begin
				adv_col = (walk_col_q - 8'd2 == 8'd6) ? 8'd5 : walk_col_q - 8'd2;
			end
		end else begin
			adv_row = walk_up_q ? walk_row_q - 8'd1 : walk_row_q + 8'd1;
			adv_col = (walk_col_q == 8'd6) ? 8'd5 : walk_col_q;
		end
	end

	// store port selection
	always_comb begin
		rd_addr = (state_q == ST_IDLE) ?
		          AW'(req.read_row) * SIDE_A + AW'(req.read_col) : walk_addr;
		wr_en   = 1'b0;
		wr_addr = walk_addr;
		wr_data = bit_q ? CODE_BLACK : CODE_WHITE;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = AW'(clr_r_q) * SIDE_A + AW'(clr_c_q);
			wr_data = fix_code;
		end else if (state_q == ST_WCHK && rd_q == CODE_UNSET) begin
			wr_en = 1'b1;
		end
	end

	// module store
	always_ff @(posedge clk) begin
		if (wr_en)
			store_q[wr_addr] <= wr_data;
		rd_q <= store_q[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (req.op)
						OP_START: state_d = ST_CLEAR;
						OP_PLACE: state_d = walk_done_q ? ST_OUT : ST_WRD;
						OP_READ:  state_d = in_range ? ST_RWAIT : ST_OUT;
						default:  state_d = ST_OUT;
					endcase
				end
			end
			ST_CLEAR: if (clr_last) state_d = ST_OUT;
			ST_WRD:   state_d = ST_WCHK;
			ST_WCHK:  state_d = (rd_q == CODE_UNSET || adv_done) ? ST_OUT : ST_WRD;
			ST_RWAIT: state_d = ST_OUT;
			ST_OUT:   if (rsp_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q       <= 6'd1;
			act_ver_q   <= 6'd1;
			side_q      <= 8'd21;
			walk_col_q  <= '0;
			walk_row_q  <= '0;
			walk_up_q   <= 1'b1;
			walk_left_q <= 1'b0;
			walk_done_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr)
				ver_q <= pwdata[5:0];
			if (acc && req.op == OP_START) begin
				side_q    <= side_c;
				act_ver_q <= ver_c;
			end
			if (state_q == ST_CLEAR && clr_last) begin
				walk_col_q  <= side_q - 8'd1;
				walk_row_q  <= side_q - 8'd1;
				walk_up_q   <= 1'b1;
				walk_left_q <= 1'b0;
				walk_done_q <= 1'b0;
			end
			if (state_q == ST_WCHK) begin
				walk_col_q  <= adv_col;
				walk_row_q  <= adv_row;
				walk_up_q   <= adv_up;
				walk_left_q <= adv_left;
				walk_done_q <= adv_done;
			end
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload: sweep counters, result build, output register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					res_q   <= '0;
					bit_q   <= req.data_bit;
					clr_r_q <= '0;
					clr_c_q <= '0;
					if (req.op == OP_PLACE && walk_done_q)
						res_q.full_res <= 1'b1;
					if (req.op == OP_READ && !in_range)
						res_q.module_code <= CODE_RESV;
				end
			end
			ST_CLEAR: begin
				if (clr_c_q == side_q - 8'd1) begin
					clr_c_q <= '0;
					clr_r_q <= clr_r_q + 8'd1;
				end else begin
					clr_c_q <= clr_c_q + 8'd1;
				end
			end
			ST_WCHK: begin
				if (rd_q == CODE_UNSET) begin
					res_q.placed     <= 1'b1;
					res_q.placed_row <= walk_row_q;
					res_q.placed_col <= cur_col;
				end else if (adv_done) begin
					res_q.full_res <= 1'b1;
				end
			end
			ST_RWAIT: res_q.module_code <= rd_q;
			ST_OUT:   if (rsp_load) rsp_q <= res_q;
			default: ;
		endcase
	end

endmodule

// ----- rtl/qmp_fixed_marks.sv -----
// Code of one module after the fixed marks are drawn on a cleared symbol.
module qmp_fixed_marks
	import qmp_pkg::*;
(
	input  logic [7:0] row,
	input  logic [7:0] col,
	input  logic [7:0] side,
	input  logic [5:0] ver,
	output logic [1:0] code
);

	align_row_t arow;
	logic [7:0] last;
	logic       hit_r, hit_c;
	logic [7:0] ar, ac;

	assign arow = align_row(ver);
	assign last = side - 8'd7;

	// Find the alignment center row and column within two modules
	always_comb begin
		hit_r = 1'b0;
		hit_c = 1'b0;
		ar    = '0;
		ac    = '0;
		for (int i = 1; i < 8; i++) begin
			if (8'(i) <= arow[0]) begin
				if ({1'b0, row} + 9'd2 >= {1'b0, arow[i]} &&
				    {1'b0, row} <= {1'b0, arow[i]} + 9'd2) begin
					hit_r = 1'b1;
					ar    = arow[i];
				end
				if ({1'b0, col} + 9'd2 >= {1'b0, arow[i]} &&
				    {1'b0, col} <= {1'b0, arow[i]} + 9'd2) begin
					hit_c = 1'b1;
					ac    = arow[i];
				end
			end
		end
	end

	// Priority: version > format > alignment > dark module > separators > finders; timing fills only unset
	always_comb begin
		logic [7:0] fr, fc;
		logic       in_fnd, sep, skip, fmt, vers;
		fr     = '0;
		fc     = '0;
		in_fnd = 1'b0;
		code   = CODE_UNSET;

		// finder squares
		if (row < 8'd7 && col < 8'd7) begin
			in_fnd = 1'b1; fr = row; fc = col;
		end else if (row >= last && col < 8'd7) begin
			in_fnd = 1'b1; fr = row - last; fc = col;
		end else if (row < 8'd7 && col >= last) begin
			in_fnd = 1'b1; fr = row; fc = col - last;
		end
		if (in_fnd) begin
			if (fr == 8'd0 || fr == 8'd6 || fc == 8'd0 || fc == 8'd6 ||
			    (fr >= 8'd2 && fr <= 8'd4 && fc >= 8'd2 && fc <= 8'd4))
				code = CODE_BLACK;
			else
				code = CODE_WHITE;
		end

		// separators and dark module
		sep = (row == 8'd7 && col <= 8'd7) || (col == 8'd7 && row <= 8'd7) ||
		      (row == side - 8'd8 && col <= 8'd7) ||
		      (col == 8'd7 && row >= side - 8'd8) ||
		      (row == 8'd7 && col >= side - 8'd8) ||
		      (col == side - 8'd8 && row <= 8'd7);
		if (sep)
			code = CODE_WHITE;
		if (row == side - 8'd8 && col == 8'd8)
			code = CODE_BLACK;

		// alignment squares, skipping centers under a finder
		skip = (ar == 8'd6 && ac == 8'd6) || (ar == 8'd6 && ac == last) ||
		       (ar == last && ac == 8'd6);
		if (hit_r && hit_c && !skip) begin
			if (row == ar - 8'd2 || row == ar + 8'd2 || col == ac - 8'd2 ||
			    col == ac + 8'd2 || (row == ar && col == ac))
				code = CODE_BLACK;
			else
				code = CODE_WHITE;
		end

		// timing row and column fill only unset modules
		if (code == CODE_UNSET) begin
			if (row == 8'd6 && col >= 8'd8 && col <= side - 8'd9)
				code = col[0] ? CODE_WHITE : CODE_BLACK;
			else if (col == 8'd6 && row >= 8'd8 && row <= side - 8'd9)
				code = row[0] ? CODE_WHITE : CODE_BLACK;
		end

		// format reserve
		fmt = (col == 8'd8 && row >= side - 8'd7) ||
		      (row == 8'd8 && col >= side - 8'd8) ||
		      (row == 8'd8 && col <= 8'd5) || (col == 8'd8 && row <= 8'd5) ||
		      (row == 8'd8 && col == 8'd7) || (row == 8'd7 && col == 8'd8) ||
		      (row == 8'd8 && col == 8'd8);
		if (fmt)
			code = CODE_RESV;

		// version reserve
		vers = (ver >= 6'd7) &&
		       ((row >= side - 8'd11 && row <= side - 8'd9 && col <= 8'd5) ||
		        (col >= side - 8'd11 && col <= side - 8'd9 && row <= 8'd5));
		if (vers)
			code = CODE_RESV;
	end

endmodule

// ----- rtl/qmp_checker.sv -----
`include "assert_macros.svh"

// Port-level checks on the result channel.
module qmp_props
	import qmp_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input qmp_rsp_t rsp
);

	`QMP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`QMP_ASSERT_IMP(a_placed_xor_full, rsp_valid, !(rsp.placed && rsp.full_res))
	`QMP_ASSERT_IMP(a_pos_zero, rsp_valid && !rsp.placed, rsp.placed_row == 8'd0 && rsp.placed_col == 8'd0)
	`QMP_ASSERT_IMP(a_code_zero, rsp_valid && (rsp.placed || rsp.full_res), rsp.module_code == CODE_BLACK)

endmodule

bind qr_matrix_module_placer qmp_props u_qmp_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
